// ===== rtl/core/kpst_pkg.sv =====
// Shared types and codes of the keyed priority sorted table.
// Used by the table cell, the top level, the checker and the testbench; no dependencies.
package kpst_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_FILTER = 2'd3;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_DUP     = 3'd1;
  localparam logic [2:0] STAT_MISSING = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_NOMATCH = 3'd4;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  prio;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [9:0]  volumes;
  } entry_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t cand;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/kpst_if.sv =====
// Handshake channels of the keyed priority sorted table: command in, result out.
// Depends on nothing; carries valid, ready and the payload fields.
interface kpst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] order_key;
  logic [7:0]  priority_req;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [9:0]  volumes;

  modport source (output valid, mode, order_key, priority_req, day, month, year, volumes,
                  input ready);
  modport sink (input valid, mode, order_key, priority_req, day, month, year, volumes,
                output ready);
endinterface

interface kpst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] found_key;
  logic [7:0]  found_priority;
  logic [4:0]  found_day;
  logic [3:0]  found_month;
  logic [13:0] found_year;
  logic [9:0]  found_volumes;
  logic        last;

  modport source (output valid, status, found_key, found_priority, found_day, found_month,
                  found_year, found_volumes, last, input ready);
  modport sink (input valid, status, found_key, found_priority, found_day, found_month,
                found_year, found_volumes, last, output ready);
endinterface

// ===== rtl/core/keyed_priority_sorted_table_core.sv =====
// Top level of the keyed priority sorted table: command control, cell chain, result register.
// Depends on kpst_pkg, kpst_if (kpst_in_if, kpst_out_if) and kpst_cell.
//
//  channel  dir  beat carries
//  in_i     in   mode, order_key, priority_req, day, month, year, volumes
//  out_o    out  status, found_key .. found_volumes, last
//
// An accepted command is registered and executed in the ST_EXEC state. Insert, remove and
// lookup give one result beat each, and so does a filter without a match. A filter with
// matches then gives one result beat per matching entry in ST_FILT, one beat per cycle
// while out_o is ready. Execution waits while the result register is full and out_o is not
// ready. Reset clears the entry count and the control; entries need no clearing.
module keyed_priority_sorted_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  kpst_in_if.sink    in_i,
  kpst_out_if.source out_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FILT = 2'd2;

  typedef struct packed {
    logic [2:0]       status;
    kpst_pkg::entry_t ent;
    logic             last;
  } res_t;

  logic [1:0]       state_q, state_d;
  logic [1:0]       mode_q;
  kpst_pkg::entry_t cand_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [TABLE_DEPTH-1:0] mask_q, mask_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  kpst_pkg::cell_ctrl_t   ctrl;
  kpst_pkg::entry_t       entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stay_w, match_w, seen_w, prio_eq_w;

  logic                   in_fire, out_free, hit, full;
  logic [TABLE_DEPTH-1:0] low_bit, rest;
  kpst_pkg::entry_t       hit_entry, low_entry;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign hit      = |match_w;
  assign full     = (count_q == CntW'(TABLE_DEPTH));
  assign low_bit  = mask_q & (~mask_q + TABLE_DEPTH'(1));
  assign rest     = mask_q & ~low_bit;

  // Cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kpst_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CntW'(i) < count_q),
      .left_entry_i  ((i == 0) ? cand_q : entry_w[(i == 0) ? 0 : i - 1]),
      .left_stay_i   ((i == 0) ? 1'b1 : stay_w[(i == 0) ? 0 : i - 1]),
      .right_entry_i (entry_w[(i == TABLE_DEPTH - 1) ? i : i + 1]),
      .seen_i        ((i == 0) ? 1'b0 : seen_w[(i == 0) ? 0 : i - 1]),
      .entry_o       (entry_w[i]),
      .stay_o        (stay_w[i]),
      .match_o       (match_w[i]),
      .seen_o        (seen_w[i]),
      .prio_eq_o     (prio_eq_w[i])
    );
  end

  // One-hot selects of the key hit and of the lowest pending filter match
  always_comb begin
    hit_entry = '0;
    low_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_entry = hit_entry | (entry_w[i] & {$bits(kpst_pkg::entry_t){match_w[i]}});
      low_entry = low_entry | (entry_w[i] & {$bits(kpst_pkg::entry_t){low_bit[i]}});
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    ctrl.cand   = cand_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode_q == kpst_pkg::MODE_FILTER && (|prio_eq_w)) begin
          mask_d  = prio_eq_w;
          state_d = ST_FILT;
        end else if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          res_d       = '0;
          res_d.last  = 1'b1;
          unique case (mode_q)
            kpst_pkg::MODE_INSERT: begin
              if (hit) begin
                res_d.status = kpst_pkg::STAT_DUP;
              end else if (full) begin
                res_d.status = kpst_pkg::STAT_FULL;
              end else begin
                res_d.status = kpst_pkg::STAT_OK;
                ctrl.ins     = 1'b1;
                count_d      = count_q + CntW'(1);
              end
            end
            kpst_pkg::MODE_REMOVE: begin
              if (hit) begin
                res_d.status = kpst_pkg::STAT_OK;
                ctrl.rem     = 1'b1;
                count_d      = count_q - CntW'(1);
              end else begin
                res_d.status = kpst_pkg::STAT_MISSING;
              end
            end
            kpst_pkg::MODE_LOOKUP: begin
              if (hit) begin
                res_d.status = kpst_pkg::STAT_OK;
                res_d.ent    = hit_entry;
              end else begin
                res_d.status = kpst_pkg::STAT_MISSING;
              end
            end
            default: begin
              res_d.status = kpst_pkg::STAT_NOMATCH;
            end
          endcase
        end
      end
      ST_FILT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          res_d.status = kpst_pkg::STAT_OK;
          res_d.ent    = low_entry;
          res_d.last   = (rest == '0);
          mask_d       = rest;
          if (rest == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q         <= in_i.mode;
      cand_q.key     <= in_i.order_key;
      cand_q.prio    <= in_i.priority_req;
      cand_q.day     <= in_i.day;
      cand_q.month   <= in_i.month;
      cand_q.year    <= in_i.year;
      cand_q.volumes <= in_i.volumes;
    end
    res_q <= res_d;
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.found_key      = res_q.ent.key;
  assign out_o.found_priority = res_q.ent.prio;
  assign out_o.found_day      = res_q.ent.day;
  assign out_o.found_month    = res_q.ent.month;
  assign out_o.found_year     = res_q.ent.year;
  assign out_o.found_volumes  = res_q.ent.volumes;
  assign out_o.last           = res_q.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> $countones(match_w) <= 1)
    else $error("key held by more than one entry");

  a_filt_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILT |-> mask_q != '0)
    else $error("filter scan with no pending match");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the table");

endmodule

// ===== rtl/core/kpst_cell.sv =====
// One slot of the sorted table chain: holds an entry, compares it with the command
// and on insert takes the new entry or its left neighbor, on remove its right one. Uses kpst_pkg.
module kpst_cell (
  input  logic                clk_i,
  input  kpst_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  kpst_pkg::entry_t    left_entry_i,
  input  logic                left_stay_i,
  input  kpst_pkg::entry_t    right_entry_i,
  input  logic                seen_i,
  output kpst_pkg::entry_t    entry_o,
  output logic                stay_o,
  output logic                match_o,
  output logic                seen_o,
  output logic                prio_eq_o
);

  kpst_pkg::entry_t entry_q, entry_d;

  // Entries at or above the new priority stay put; they form a prefix of the chain.
  assign stay_o    = occupied_i && (entry_q.prio >= ctrl_i.cand.prio);
  assign match_o   = occupied_i && (entry_q.key == ctrl_i.cand.key);
  assign prio_eq_o = occupied_i && (entry_q.prio == ctrl_i.cand.prio);
  // Ripple the key hit down the chain: every slot from the hit onward moves left.
  assign seen_o    = seen_i || match_o;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !stay_o) begin
      entry_d = left_stay_i ? ctrl_i.cand : left_entry_i;
    end else if (ctrl_i.rem && seen_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== test/kpst_table_checker.sv =====
// Checker of the keyed priority sorted table: keeps a shadow of the sorted table,
// predicts the result beats of each command beat and compares them field by field.
// Depends on kpst_pkg and the kpst_in_if / kpst_out_if channels.
module kpst_table_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  kpst_in_if   cmd_mon,
  kpst_out_if  res_mon,
  output int   pending_o,
  output int   err_count_o
);

  typedef struct packed {
    logic [2:0]       status;
    kpst_pkg::entry_t ent;
    logic             last;
  } table_result_t;

  kpst_pkg::entry_t shadow_tbl [TABLE_DEPTH];
  int               shadow_cnt;
  table_result_t    want_q [$];

  function automatic int key_slot(logic [15:0] k);
    for (int i = 0; i < shadow_cnt; i++)
      if (shadow_tbl[i].key == k) return i;
    return -1;
  endfunction

  function automatic void queue_result(logic [2:0] st, kpst_pkg::entry_t e, logic lst);
    table_result_t r;
    r.status = st;
    r.ent    = e;
    r.last   = lst;
    want_q.push_back(r);
  endfunction

  function automatic void apply_command(logic [1:0] op, kpst_pkg::entry_t cand);
    int slot;
    int at;
    int last_hit;
    slot = key_slot(cand.key);
    case (op)
      kpst_pkg::MODE_INSERT: begin
        // duplicate wins over full
        if (slot >= 0) queue_result(kpst_pkg::STAT_DUP, '0, 1'b1);
        else if (shadow_cnt >= TABLE_DEPTH) queue_result(kpst_pkg::STAT_FULL, '0, 1'b1);
        else begin
          at = 0;
          while (at < shadow_cnt && shadow_tbl[at].prio >= cand.prio) at++;
          for (int i = shadow_cnt; i > at; i--) shadow_tbl[i] = shadow_tbl[i-1];
          shadow_tbl[at] = cand;
          shadow_cnt++;
          queue_result(kpst_pkg::STAT_OK, '0, 1'b1);
        end
      end
      kpst_pkg::MODE_REMOVE: begin
        if (slot < 0) queue_result(kpst_pkg::STAT_MISSING, '0, 1'b1);
        else begin
          for (int i = slot; i + 1 < shadow_cnt; i++) shadow_tbl[i] = shadow_tbl[i+1];
          shadow_cnt--;
          queue_result(kpst_pkg::STAT_OK, '0, 1'b1);
        end
      end
      kpst_pkg::MODE_LOOKUP: begin
        if (slot < 0) queue_result(kpst_pkg::STAT_MISSING, '0, 1'b1);
        else queue_result(kpst_pkg::STAT_OK, shadow_tbl[slot], 1'b1);
      end
      default: begin
        last_hit = -1;
        for (int i = 0; i < shadow_cnt; i++)
          if (shadow_tbl[i].prio == cand.prio) last_hit = i;
        if (last_hit < 0) queue_result(kpst_pkg::STAT_NOMATCH, '0, 1'b1);
        else begin
          for (int i = 0; i < shadow_cnt; i++)
            if (shadow_tbl[i].prio == cand.prio)
              queue_result(kpst_pkg::STAT_OK, shadow_tbl[i], i == last_hit);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t    want;
    kpst_pkg::entry_t cand;
    if (!rst_ni) begin
      shadow_cnt  = 0;
      want_q.delete();
      pending_o   = 0;
      err_count_o = 0;
    end else begin
      // retire the result beat first; a command beat cannot answer in the same cycle
      if (res_mon.valid && res_mon.ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result beat: status %0d key %0d", res_mon.status,
                 res_mon.found_key);
          err_count_o++;
        end else begin
          want = want_q.pop_front();
          check_field("status", 32'(want.status), 32'(res_mon.status));
          check_field("found_key", 32'(want.ent.key), 32'(res_mon.found_key));
          check_field("found_priority", 32'(want.ent.prio), 32'(res_mon.found_priority));
          check_field("found_day", 32'(want.ent.day), 32'(res_mon.found_day));
          check_field("found_month", 32'(want.ent.month), 32'(res_mon.found_month));
          check_field("found_year", 32'(want.ent.year), 32'(res_mon.found_year));
          check_field("found_volumes", 32'(want.ent.volumes), 32'(res_mon.found_volumes));
          check_field("last", 32'(want.last), 32'(res_mon.last));
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        cand = '{key: cmd_mon.order_key, prio: cmd_mon.priority_req, day: cmd_mon.day,
                 month: cmd_mon.month, year: cmd_mon.year, volumes: cmd_mon.volumes};
        apply_command(cmd_mon.mode, cand);
      end
      pending_o = want_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top of the keyed priority sorted table: clock, reset, command and
// result-side traffic with random gaps, and the verdict.
// Depends on kpst_pkg, kpst_if, keyed_priority_sorted_table_core and kpst_table_checker.
module tb_top;

  localparam int DEPTH       = 16;
  localparam int RANDOM_CMDS = 305;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i;
  logic rst_ni;
  int   cyc = 0;
  int   pending;
  int   err_count;
  logic [15:0] key_pool [32];
  logic [7:0]  hot_prios [6] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd255};

  kpst_in_if  cmd_ch ();
  kpst_out_if res_ch ();

  keyed_priority_sorted_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  kpst_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_mon     (cmd_ch),
    .res_mon     (res_ch),
    .pending_o   (pending),
    .err_count_o (err_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  // windows with no random gaps on either side
  function automatic bit calm();
    return ((cyc / 256) % 5) == 2;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm()) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 31)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_prio();
    if ($urandom_range(0, 99) < 70) return hot_prios[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // bias 0 fills the table, 1 drains it, 2 mixes
  function automatic logic [1:0] pick_op(int bias);
    int r;
    int t_ins;
    int t_rem;
    int t_look;
    r = $urandom_range(0, 99);
    case (bias)
      0:       begin t_ins = 60; t_rem = 75; t_look = 88; end
      1:       begin t_ins = 15; t_rem = 70; t_look = 85; end
      default: begin t_ins = 35; t_rem = 60; t_look = 80; end
    endcase
    if (r < t_ins) return kpst_pkg::MODE_INSERT;
    if (r < t_rem) return kpst_pkg::MODE_REMOVE;
    if (r < t_look) return kpst_pkg::MODE_LOOKUP;
    return kpst_pkg::MODE_FILTER;
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [15:0] k, logic [7:0] p, logic [4:0] d,
                          logic [3:0] m, logic [13:0] y, logic [9:0] v);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.mode         = op;
    cmd_ch.order_key    = k;
    cmd_ch.priority_req = p;
    cmd_ch.day          = d;
    cmd_ch.month        = m;
    cmd_ch.year         = y;
    cmd_ch.volumes      = v;
    cmd_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  // result side: random stalls plus one long hold-off so the table backs up
  initial begin
    int hold_left;
    int rx_cyc;
    hold_left    = 0;
    rx_cyc       = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if (rx_cyc == 400) hold_left = 220;
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        res_ch.ready = 1'b1;
        if (!calm() && $urandom_range(0, 99) < 30) hold_left = pick_gap();
      end
    end
  end

  initial begin
    logic [7:0] fill_prios [13] = '{8'd7, 8'd7, 8'd0, 8'd255, 8'd7, 8'd3, 8'd0, 8'd7,
                                    8'd255, 8'd3, 8'd7, 8'd0, 8'd7};
    int bias;
    rst_ni              = 1'b0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.mode         = kpst_pkg::MODE_INSERT;
    cmd_ch.order_key    = '0;
    cmd_ch.priority_req = '0;
    cmd_ch.day          = '0;
    cmd_ch.month        = '0;
    cmd_ch.year         = '0;
    cmd_ch.volumes      = '0;
    bias                = 2;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 65535));
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'(i - 1);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: no match, misses
    send_cmd(kpst_pkg::MODE_FILTER, 16'd0, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_LOOKUP, 16'd5, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_REMOVE, 16'd5, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);
    // field extremes
    send_cmd(kpst_pkg::MODE_INSERT, 16'h0000, 8'h00, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_INSERT, 16'hFFFF, 8'hFF, 5'd31, 4'd15, 14'd16383, 10'd1023);
    // fill up with repeated priorities to exercise arrival order
    for (int i = 0; i < 13; i++)
      send_cmd(kpst_pkg::MODE_INSERT, 16'(i + 1), fill_prios[i], 5'(i + 1), 4'(i % 12 + 1),
               14'(2000 + i), 10'(i * 17));
    send_cmd(kpst_pkg::MODE_INSERT, 16'd100, 8'd7, 5'd9, 4'd9, 14'd9999, 10'd512);
    // duplicate on a full table, then plain full
    send_cmd(kpst_pkg::MODE_INSERT, 16'h0000, 8'd1, 5'd1, 4'd1, 14'd1, 10'd1);
    send_cmd(kpst_pkg::MODE_INSERT, 16'd200, 8'd1, 5'd1, 4'd1, 14'd1, 10'd1);
    send_cmd(kpst_pkg::MODE_FILTER, 16'd0, 8'd7, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_LOOKUP, 16'hFFFF, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_REMOVE, 16'h0000, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);
    send_cmd(kpst_pkg::MODE_FILTER, 16'd0, 8'd0, 5'd0, 4'd0, 14'd0, 10'd0);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(0, 2);
      send_cmd(pick_op(bias), pick_key(), pick_prio(), 5'($urandom_range(0, 31)),
               4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)),
               10'($urandom_range(0, 1023)));
    end
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("[keyed_priority_sorted_table_core] OK");
    end else begin
      $display("[keyed_priority_sorted_table_core] ERROR");
    end
    $finish;
  end

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("[keyed_priority_sorted_table_core] ERROR");
    $finish;
  end

endmodule

// ===== keyed_priority_sorted_table_core.f =====
rtl/core/kpst_pkg.sv
rtl/core/kpst_if.sv
rtl/core/kpst_cell.sv
rtl/core/keyed_priority_sorted_table_core.sv
test/kpst_table_checker.sv
test/tb_top.sv
